// ===== rtl/sle_pkg.sv =====
// Package for the search line edge locator.
// Holds the shared types, register indexes, reset values and helper functions.
// No dependencies; every other file of the block but sle_if uses it.
`default_nettype none

package sle_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_HALF_LENGTH        = 2'd0;
  localparam logic [1:0] REG_COLOR_MODE         = 2'd1;
  localparam logic [1:0] REG_STRENGTH_THRESHOLD = 2'd2;

  // Register reset values.
  localparam logic [6:0] RST_HALF_LENGTH        = 7'd8;
  localparam logic       RST_COLOR_MODE         = 1'b0;
  localparam logic [7:0] RST_STRENGTH_THRESHOLD = 8'd20;

  // Depth of the operation queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Effective configuration, half length already clamped.
  typedef struct packed {
    logic [6:0] len;
    logic       color;
    logic [7:0] thr;
  } sle_cfg_t;

  // One classified pixel as handed from front to back.
  typedef struct packed {
    logic       off1;    // offer an interior column
    logic       force1;  // that column is the first searched one
    logic [7:0] k1;
    logic [7:0] s1;
    logic       off2;    // offer the last column with strength zero
    logic [7:0] k2;
    logic       emit;    // this pixel ends the line
  } sle_op_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } sle_qstat_t;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sle_if.sv =====
// Channel interfaces of the search line edge locator: pixels, results, configuration.
// Depends on nothing; valid/ready handshake with a source and a sink modport.
`default_nettype none

interface sle_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan0;
  logic [7:0] chan1;
  logic [7:0] chan2;
  modport source (output valid, output chan0, output chan1, output chan2, input ready);
  modport sink   (input valid, input chan0, input chan1, input chan2, output ready);
endinterface

interface sle_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] best_column;
  logic [7:0] peak_strength;
  logic       accepted;
  modport source (output valid, output best_column, output peak_strength,
                  output accepted, input ready);
  modport sink   (input valid, input best_column, input peak_strength,
                  input accepted, output ready);
endinterface

interface sle_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sle_front.sv =====
// Front of the search line edge locator: takes pixels, forms gradients and
// classifies each pixel into an operation. Depends on sle_pkg and sle_if.
`default_nettype none

module sle_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  sle_pkg::sle_cfg_t   cfg_i,
  sle_pix_if.sink             pix_i,
  input  sle_pkg::sle_qstat_t qstat_i,
  output logic                push_o,
  output sle_pkg::sle_op_t    op_o
);

  logic [7:0]  col_q, col_d;
  logic [23:0] prev0_q, prev1_q;
  logic [7:0]  last;
  logic [7:0]  g0, g1, g2, grad;
  logic        accept;

  assign pix_i.ready = !qstat_i.full;
  assign accept      = pix_i.valid && pix_i.ready;
  assign last        = {cfg_i.len, 1'b0};

  // Central difference against the pixel two columns back.
  assign g0 = sle_pkg::absdiff(pix_i.chan0, prev1_q[7:0]);
  assign g1 = sle_pkg::absdiff(pix_i.chan1, prev1_q[15:8]);
  assign g2 = sle_pkg::absdiff(pix_i.chan2, prev1_q[23:16]);

  always_comb begin
    grad = g0;
    if (cfg_i.color) begin
      if (g1 > grad) grad = g1;
      if (g2 > grad) grad = g2;
    end
  end

  always_comb begin
    op_o.off1   = (col_q >= 8'd3) && (col_q <= last);
    op_o.k1     = col_q - 8'd1;
    op_o.force1 = (col_q == 8'd3);
    op_o.s1     = grad;
    op_o.off2   = (col_q == last);
    op_o.k2     = last;
    op_o.emit   = (col_q >= last);
  end

  assign push_o = accept;
  assign col_d  = op_o.emit ? 8'd0 : col_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= 8'd0;
    end else if (accept) begin
      col_q <= col_d;
    end
  end

  // Pixel history needs no reset: it is read only from the fourth pixel on.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev1_q <= prev0_q;
      prev0_q <= {pix_i.chan2, pix_i.chan1, pix_i.chan0};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sle_queue.sv =====
// Short queue of classified operations between front and back.
// Depends on sle_pkg.
`default_nettype none

module sle_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  sle_pkg::sle_op_t    op_i,
  input  wire                 pop_i,
  output sle_pkg::sle_op_t    head_o,
  output sle_pkg::sle_qstat_t qstat_o
);

  localparam logic [sle_pkg::QPTR_W-1:0] PTR_LAST = sle_pkg::QPTR_W'(sle_pkg::QDEPTH - 1);
  localparam logic [sle_pkg::QCNT_W-1:0] CNT_FULL = sle_pkg::QCNT_W'(sle_pkg::QDEPTH);

  sle_pkg::sle_op_t                entry_q [sle_pkg::QDEPTH];
  logic [sle_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [sle_pkg::QCNT_W-1:0]      cnt_q, cnt_d;

  assign head_o        = entry_q[rd_ptr_q];
  assign qstat_o.full  = (cnt_q == CNT_FULL);
  assign qstat_o.empty = (cnt_q == '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= op_i;
  end

endmodule

`default_nettype wire

// ===== rtl/sle_back.sv =====
// Back of the search line edge locator: applies offers to the running best
// column and registers the line result. Depends on sle_pkg and sle_if.
`default_nettype none

module sle_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  sle_pkg::sle_cfg_t   cfg_i,
  input  sle_pkg::sle_op_t    head_i,
  input  sle_pkg::sle_qstat_t qstat_i,
  output logic                pop_o,
  sle_res_if.source           res_o
);

  logic [7:0] best_s_q, best_k_q;
  logic [7:0] mid_s, mid_k, new_s, new_k;
  logic [7:0] ct;
  logic       out_valid_q;
  logic [7:0] out_col_q, out_str_q;
  logic       out_acc_q;
  logic       out_free;

  assign ct       = {1'b0, cfg_i.len} + 8'd1;
  assign out_free = !out_valid_q || res_o.ready;
  assign pop_o    = !qstat_i.empty && (!head_i.emit || out_free);

  // Two offers may fall on one pixel: the interior column, then the last column.
  always_comb begin
    mid_s = best_s_q;
    mid_k = best_k_q;
    if (head_i.off1 && (head_i.force1 || head_i.s1 > best_s_q ||
        (head_i.s1 == best_s_q &&
         sle_pkg::absdiff(head_i.k1, ct) <= sle_pkg::absdiff(best_k_q, ct)))) begin
      mid_s = head_i.s1;
      mid_k = head_i.k1;
    end
    new_s = mid_s;
    new_k = mid_k;
    if (head_i.off2 && (head_i.k2 == 8'd2 || (mid_s == 8'd0 &&
        sle_pkg::absdiff(head_i.k2, ct) <= sle_pkg::absdiff(mid_k, ct)))) begin
      new_s = 8'd0;
      new_k = head_i.k2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_s_q    <= 8'd0;
      best_k_q    <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        best_s_q <= head_i.emit ? 8'd0 : new_s;
        best_k_q <= head_i.emit ? 8'd0 : new_k;
      end
      if (pop_o && head_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.emit) begin
      out_col_q <= new_k;
      out_str_q <= new_s;
      out_acc_q <= (new_s > cfg_i.thr);
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.best_column   = out_col_q;
  assign res_o.peak_strength = out_str_q;
  assign res_o.accepted      = out_acc_q;

endmodule

`default_nettype wire

// ===== rtl/search_line_edge_locator_top.sv =====
// Top level of the search line edge locator.
// Depends on sle_pkg, sle_if, sle_front, sle_queue and sle_back.
`default_nettype none

// The block takes the pixels of one search line of 2*half_length+1 pixels,
// left to right, one pixel per transfer, and at the line's last pixel gives
// one result: the column with the strongest central-difference gradient among
// columns 2 to 2*half_length, its magnitude, and a flag set when the magnitude
// exceeds strength_threshold. Equal magnitudes go to the column nearest
// half_length+1, and at equal distance to the right one. In color mode the
// gradient is the largest of the three channel gradients. A half_length of
// zero acts as one and one above MAX_HALF_LENGTH acts as MAX_HALF_LENGTH.
// The block takes one pixel every clock. The front forms the gradient and
// classifies the pixel, a two-entry queue carries it to the back, and the back
// updates the best column as it takes each pixel from the queue; the line's
// last pixel passes through the queue entry and then the result register
// before the result is offered. The pixel input stalls only when the result
// register is held by the sink and the queue has filled.
// Configuration is taken every clock and should be written between lines.

module search_line_edge_locator_top #(
  parameter int unsigned MAX_HALF_LENGTH = 64
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  sle_cfg_if.sink   cfg_i,
  sle_pix_if.sink   pix_i,
  sle_res_if.source res_o
);

  localparam logic [6:0] MAX_LEN = 7'(MAX_HALF_LENGTH);

  logic [6:0]          half_length_q;
  logic                color_mode_q;
  logic [7:0]          threshold_q;
  sle_pkg::sle_cfg_t   cfg;
  sle_pkg::sle_op_t    push_op, head_op;
  sle_pkg::sle_qstat_t qstat;
  logic                push, pop;

  // Configuration registers; indexes beyond the list are ignored.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_length_q <= sle_pkg::RST_HALF_LENGTH;
      color_mode_q  <= sle_pkg::RST_COLOR_MODE;
      threshold_q   <= sle_pkg::RST_STRENGTH_THRESHOLD;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        sle_pkg::REG_HALF_LENGTH:        half_length_q <= cfg_i.data[6:0];
        sle_pkg::REG_COLOR_MODE:         color_mode_q  <= cfg_i.data[0];
        sle_pkg::REG_STRENGTH_THRESHOLD: threshold_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Clamp the half length into its working range.
  always_comb begin
    cfg.len = half_length_q;
    if (half_length_q == 7'd0)   cfg.len = 7'd1;
    if (half_length_q > MAX_LEN) cfg.len = MAX_LEN;
    cfg.color = color_mode_q;
    cfg.thr   = threshold_q;
  end

  sle_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .pix_i   (pix_i),
    .qstat_i (qstat),
    .push_o  (push),
    .op_o    (push_op)
  );

  sle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .pop_i   (pop),
    .head_o  (head_op),
    .qstat_o (qstat)
  );

  sle_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .head_i  (head_op),
    .qstat_i (qstat),
    .pop_o   (pop),
    .res_o   (res_o)
  );

  // The front never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.full |-> !push)
    else $error("operation queue overflow");

  // The back never takes from an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.empty |-> !pop)
    else $error("operation queue underflow");

  // Column one is never searched, so it can never be reported.
  a_col_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.best_column != 8'd1))
    else $error("result reports column one");

  // A popped end-of-line operation shows up as a result on the next clock.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head_op.emit) |=> res_o.valid)
    else $error("line end without result");

endmodule

`default_nettype wire
